>>> src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int BLK_NUM_W = 12;  // block_number / allocated_block width
    localparam int TOTAL_W   = 13;  // total_blocks width, also the block limit
    localparam int SCAN_W    = 14;  // block arithmetic inside a map word scan

    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic CFG_TOTAL_BLOCKS      = 1'b0;
    localparam logic CFG_FIRST_ALLOC_BLOCK = 1'b1;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [BLK_NUM_W-1:0] block_number;
    } cmd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 is_free;
        logic [BLK_NUM_W-1:0] allocated_block;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_FREE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/bba_find.sv
// ----------------------------------------------------------------------------
// bba_find
// Lowest set bit of a map word whose block lies in [lo, hi).
// ----------------------------------------------------------------------------
`default_nettype none

module bba_find
    import bba_pkg::*;
#(
    parameter int W  = 32,
    parameter int OW = $clog2(W)
) (
    input  wire logic [W-1:0]      word,
    input  wire logic [SCAN_W-1:0] base,
    input  wire logic [SCAN_W-1:0] lo,
    input  wire logic [SCAN_W-1:0] hi,
    output logic                   found,
    output logic      [OW-1:0]     pos
);

    logic [W-1:0] cand;

    always_comb
    begin
        logic [SCAN_W-1:0] blk;
        for (int i = 0; i < W; i++)
        begin
            blk     = base + SCAN_W'(i);
            cand[i] = word[i] && (blk >= lo) && (blk < hi);
        end
    end

    always_comb
    begin
        found = |cand;
        pos   = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pos = OW'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> src/bitmap_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit free-block bitmap allocator; one map bit per block, set = free.
// ----------------------------------------------------------------------------
// Command channel cmd (valid/stall) carries opcode and block_number; each
// command returns one transaction on rsp (valid/stall) with status, is_free
// and allocated_block. Registers total_blocks and first_alloc_block are set
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce this. One command is
// in flight at a time. Range and zero rejections go from accept straight to
// the response; query and free do one map read, then lookup or write-back.
// Allocate reads one map word per cycle starting at the word of
// first_alloc_block. The next command is taken in the cycle after the
// response is loaded. After reset the map is cleared to all in use, one
// word per cycle over all NUM_BLOCKS / MAP_WORD_BITS words; cmd_stall is
// high during that pass. A finished response sits in the output register
// while the next command is accepted; a stalled receiver holds it there and
// the following command waits before its own response.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS    = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire cmd_t               cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output rsp_t                    rsp,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [TOTAL_W-1:0] cfg_data
);

    localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OW        = $clog2(MAP_WORD_BITS);
    localparam logic [16:0] NB = 17'(NUM_BLOCKS);

    state_t                   state_reg, state_next;
    logic [AW-1:0]            word_reg, word_next;
    logic [OW-1:0]            bit_reg, bit_next;
    logic [SCAN_W-1:0]        base_reg, base_next;
    rsp_t                     res_reg, res_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_reg, rsp_next;
    logic [TOTAL_W-1:0]       total_blocks_reg;
    logic [BLK_NUM_W-1:0]     first_alloc_block_reg;

    logic [TOTAL_W-1:0]       limit;
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata;
    logic                     find_found;
    logic [OW-1:0]            find_pos;
    logic [SCAN_W-1:0]        next_base;

    assign limit = ({4'b0, total_blocks_reg} < NB) ? total_blocks_reg : NB[TOTAL_W-1:0];

    bba_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_find #(
        .W  (MAP_WORD_BITS),
        .OW (OW)
    ) u_find (
        .word  (ram_rdata),
        .base  (base_reg),
        .lo    ({2'b0, first_alloc_block_reg}),
        .hi    ({1'b0, limit}),
        .found (find_found),
        .pos   (find_pos)
    );

    assign next_base = base_reg + SCAN_W'(MAP_WORD_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_CLEAR;
            word_reg              <= '0;
            rsp_valid_reg         <= 1'b0;
            total_blocks_reg      <= TOTAL_W'(4096);
            first_alloc_block_reg <= BLK_NUM_W'(3);
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOTAL_BLOCKS:      total_blocks_reg      <= cfg_data;
                    CFG_FIRST_ALLOC_BLOCK: first_alloc_block_reg <= cfg_data[BLK_NUM_W-1:0];
                    default:               total_blocks_reg      <= total_blocks_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        base_reg <= base_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        base_next      = base_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        cmd_stall      = 1'b1;
        ram_we         = 1'b0;
        ram_waddr      = word_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = word_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (word_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                cmd_stall = 1'b0;
                res_next  = '{status: ST_OK, is_free: 1'b0, allocated_block: '0};
                if (cmd_valid)
                begin
                    state_next = S_DONE;
                    case (cmd.opcode)
                        OP_QUERY:
                        begin
                            if ({1'b0, cmd.block_number} >= limit)
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                word_next  = AW'(cmd.block_number / MAP_WORD_BITS);
                                bit_next   = OW'(cmd.block_number % MAP_WORD_BITS);
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(cmd.block_number / MAP_WORD_BITS);
                                state_next = S_QUERY;
                            end
                        end
                        OP_FREE:
                        begin
                            if (cmd.block_number == '0)
                            begin
                                res_next.status = ST_ZERO;
                            end
                            else if ({1'b0, cmd.block_number} >= limit)
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                word_next  = AW'(cmd.block_number / MAP_WORD_BITS);
                                bit_next   = OW'(cmd.block_number % MAP_WORD_BITS);
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(cmd.block_number / MAP_WORD_BITS);
                                state_next = S_FREE;
                            end
                        end
                        OP_ALLOC:
                        begin
                            if ({1'b0, first_alloc_block_reg} >= limit)
                            begin
                                res_next.status = ST_NO_SPACE;
                            end
                            else
                            begin
                                word_next  = AW'(first_alloc_block_reg / MAP_WORD_BITS);
                                base_next  = SCAN_W'(first_alloc_block_reg)
                                           - SCAN_W'(first_alloc_block_reg % MAP_WORD_BITS);
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(first_alloc_block_reg / MAP_WORD_BITS);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_RANGE;
                        end
                    endcase
                end
            end

            S_QUERY:
            begin
                res_next.is_free = ram_rdata[bit_reg];
                state_next       = S_DONE;
            end

            S_FREE:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata | (MAP_WORD_BITS'(1) << bit_reg);
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                if (find_found)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << find_pos);
                    res_next.allocated_block =
                        BLK_NUM_W'(base_reg + SCAN_W'(find_pos));
                    state_next = S_DONE;
                end
                else if (next_base >= {1'b0, limit})
                begin
                    res_next.status = ST_NO_SPACE;
                    state_next      = S_DONE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                    base_next = next_base;
                    ram_re    = 1'b1;
                    ram_raddr = word_reg + AW'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> test/allocator_checker.sv
// ----------------------------------------------------------------------------
// allocator_checker
// Watches the command, response and register ports of the bitmap allocator,
// keeps its own copy of the free map and the registers, predicts one
// response per accepted command and compares it field by field, in order,
// with the responses that the block hands over.
// ----------------------------------------------------------------------------

module allocator_checker
    import bba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_stall,
    input  cmd_t               cmd,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  rsp_t               rsp,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [TOTAL_W-1:0] cfg_data,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_BLOCKS = 4096;

    logic                 block_free [MAP_BLOCKS];
    logic [TOTAL_W-1:0]   total_blocks;
    logic [BLK_NUM_W-1:0] first_alloc_block;
    rsp_t                 outcomes_due [$];
    rsp_t                 want;
    int                   fail_count = 0;
    int                   i;

    assign errors = fail_count;

    function automatic rsp_t allocator_outcome(cmd_t c);
        rsp_t        r;
        int unsigned lim;
        int unsigned b;
        logic        found;
        r        = '0;
        r.status = ST_OK;
        found    = 1'b0;
        lim      = (total_blocks < MAP_BLOCKS) ? total_blocks : MAP_BLOCKS;
        case (c.opcode)
            OP_QUERY:
            begin
                if (c.block_number >= lim)
                    r.status = ST_RANGE;
                else
                    r.is_free = block_free[c.block_number];
            end
            OP_FREE:
            begin
                if (c.block_number == 0)
                    r.status = ST_ZERO;
                else if (c.block_number >= lim)
                    r.status = ST_RANGE;
                else
                    block_free[c.block_number] = 1'b1;
            end
            OP_ALLOC:
            begin
                r.status = ST_NO_SPACE;
                for (b = first_alloc_block; b < lim && !found; b++)
                begin
                    if (block_free[b])
                    begin
                        block_free[b]     = 1'b0;
                        r.allocated_block = b[BLK_NUM_W-1:0];
                        r.status          = ST_OK;
                        found             = 1'b1;
                    end
                end
            end
            default:
                r.status = ST_RANGE;
        endcase
        return r;
    endfunction

    task automatic flag(input string what, input int unsigned exp_val,
                        input int unsigned act_val);
        fail_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, what, exp_val, act_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < MAP_BLOCKS; i++)
                block_free[i] = 1'b0;
            total_blocks      = 13'd4096;
            first_alloc_block = 12'd3;
            outcomes_due.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TOTAL_BLOCKS)
                    total_blocks = cfg_data;
                else
                    first_alloc_block = cfg_data[BLK_NUM_W-1:0];
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (outcomes_due.size() == 0)
                    flag("transaction with none due", 0, 32'(rsp));
                else
                begin
                    want = outcomes_due.pop_front();
                    if (rsp.status !== want.status)
                        flag("status", want.status, rsp.status);
                    if (rsp.is_free !== want.is_free)
                        flag("is_free", want.is_free, rsp.is_free);
                    if (rsp.allocated_block !== want.allocated_block)
                        flag("allocated_block", want.allocated_block, rsp.allocated_block);
                end
            end
            if (cmd_valid && !cmd_stall)
                outcomes_due.push_back(allocator_outcome(cmd));
            pending <= outcomes_due.size();
        end
    end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the bitmap block allocator: a directed pass over the corner
// cases, then random free, allocate, query and unused-opcode traffic over a
// series of register settings, with random idling on both channels. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         RANDOM_ITEMS = 1300;
    localparam int         PHASES       = 12;
    localparam int         DRAIN_CYCLES = 140;
    localparam int         MAP_BLOCKS   = 4096;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    cmd_t               cmd       = '0;
    logic               rsp_stall = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = CFG_TOTAL_BLOCKS;
    logic [TOTAL_W-1:0] cfg_data  = '0;
    logic               cmd_stall;
    logic               rsp_valid;
    rsp_t               rsp;

    int          errors;
    int          pending;
    int          cycle_count   = 0;
    int          sent          = 0;
    int          send_idle_pct = 6;
    int          recv_idle_pct = 75;
    int unsigned total_now     = 4096;
    int unsigned first_now     = 3;

    int unsigned phase_total [PHASES] = '{4096, 8191, 64, 0, 1, 4096, 200, 4095, 33,
                                          0, 0, 0};
    int unsigned phase_first [PHASES] = '{3, 0, 0, 0, 0, 4095, 150, 1, 31, 0, 0, 0};

    bitmap_block_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    allocator_checker outcome_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** bitmap_block_allocator_core: FAILED **");
        $finish;
    end

    task automatic send_cmd(input logic [1:0] op, input logic [BLK_NUM_W-1:0] blk);
        logic taken;
        if (sent < 450)
        begin
            send_idle_pct = 6;
            recv_idle_pct = 75;
        end
        else if (sent < 900)
        begin
            send_idle_pct = 75;
            recv_idle_pct = 6;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{opcode: op, block_number: blk};
        do
        begin
            @(negedge clk);
            taken = !cmd_stall;
            @(posedge clk);
        end
        while (!taken);
        sent++;
    endtask

    task automatic write_reg(input logic idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[TOTAL_W-1:0];
        @(posedge clk);
    endtask

    // registers change only with no transaction outstanding
    task automatic reconfigure(input int unsigned total, input int unsigned first);
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
        write_reg(CFG_TOTAL_BLOCKS, total);
        write_reg(CFG_FIRST_ALLOC_BLOCK, first);
        cfg_we    <= 1'b0;
        total_now  = total & 13'h1FFF;
        first_now  = first & 12'hFFF;
    endtask

    function automatic logic [BLK_NUM_W-1:0] pick_block();
        int unsigned lim;
        lim = (total_now < MAP_BLOCKS) ? total_now : MAP_BLOCKS;
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2:       return lim[BLK_NUM_W-1:0];
            3:       return BLK_NUM_W'(lim - 1);
            4, 5:    return BLK_NUM_W'($urandom_range(4095));
            6, 7, 8: return BLK_NUM_W'(first_now + $urandom_range(63));
            default: return (lim > 0) ? BLK_NUM_W'($urandom_range(lim - 1))
                                      : BLK_NUM_W'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [1:0] pick_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return OP_FREE;
        else if (r < 75)
            return OP_ALLOC;
        else if (r < 95)
            return OP_QUERY;
        else
            return OP_UNUSED;
    endfunction

    initial
    begin
        int          p;
        int          n;
        int unsigned t;
        int unsigned f;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 4096 blocks, search from block 3
        send_cmd(OP_QUERY, 12'd0);
        send_cmd(OP_QUERY, 12'd4095);
        send_cmd(OP_ALLOC, 12'd0);
        send_cmd(OP_FREE, 12'd0);
        send_cmd(OP_FREE, 12'd4095);
        send_cmd(OP_FREE, 12'd4095);
        send_cmd(OP_QUERY, 12'd4095);
        send_cmd(OP_FREE, 12'd1);
        send_cmd(OP_FREE, 12'd3);
        send_cmd(OP_ALLOC, 12'hFFF);
        send_cmd(OP_ALLOC, 12'd0);
        send_cmd(OP_ALLOC, 12'd0);
        send_cmd(OP_QUERY, 12'd1);
        send_cmd(OP_UNUSED, 12'hFFF);
        send_cmd(OP_FREE, 12'hAAA);
        send_cmd(OP_FREE, 12'h555);
        send_cmd(OP_ALLOC, 12'd0);

        reconfigure(100, 3);
        send_cmd(OP_QUERY, 12'd100);
        send_cmd(OP_FREE, 12'd100);
        send_cmd(OP_FREE, 12'd99);
        send_cmd(OP_ALLOC, 12'd0);
        reconfigure(100, 0);
        send_cmd(OP_ALLOC, 12'd0);
        reconfigure(0, 0);
        send_cmd(OP_FREE, 12'd0);
        send_cmd(OP_QUERY, 12'd0);
        send_cmd(OP_ALLOC, 12'd0);
        reconfigure(100, 200);
        send_cmd(OP_ALLOC, 12'd0);

        for (p = 0; p < PHASES; p++)
        begin
            t = phase_total[p];
            f = phase_first[p];
            if (p >= 9)
            begin
                t = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(4096);
                f = $urandom_range(((t > 4096) ? 4096 : ((t == 0) ? 1 : t)) - 1);
            end
            reconfigure(t, f);
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
                send_cmd(pick_op(), pick_block());
        end

        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("** bitmap_block_allocator_core: PASSED **");
        else
            $display("** bitmap_block_allocator_core: FAILED **");
        $finish;
    end

endmodule
